// ----- rtl/dswa_pkg.sv -----
package dswa_pkg;

   // Field widths
   localparam int SAMPLE_W  = 10;
   localparam int REF_W     = 13;
   localparam int GAIN_W    = 16;
   localparam int VALUE_W   = 16;
   localparam int SLOPE_W   = 8;
   localparam int OFFSET_W  = 10;
   localparam int DENSITY_W = 19;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Register reset values
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(600);
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(17);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(100);

   // Window
   localparam int WINDOW_SIZE = 25;
   localparam int PTR_W       = $clog2(WINDOW_SIZE);

   // Ratiometric scaling divider
   localparam int PROD_W = GAIN_W + SAMPLE_W;
   localparam int STEP_W = $clog2(PROD_W);

   // sum / WINDOW_SIZE as multiply by rounded-up reciprocal
   localparam int AVG_SHIFT   = VALUE_W + $clog2(WINDOW_SIZE);
   localparam int AVG_RECIP_W = VALUE_W + 2;
   localparam int AVG_PROD_W  = VALUE_W + AVG_RECIP_W;
   localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(
      ((64'd1 << AVG_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

   // (avg * slope) / 100 the same way
   localparam int PCT_DIV     = 100;
   localparam int SCALED_W    = VALUE_W + SLOPE_W;
   localparam int PCT_SHIFT   = SCALED_W + $clog2(PCT_DIV);
   localparam int PCT_RECIP_W = SCALED_W + 2;
   localparam int PCT_PROD_W  = SCALED_W + PCT_RECIP_W;
   localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = PCT_RECIP_W'(
      ((64'd1 << PCT_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV));
   localparam int QUOT_W = DENSITY_W - 1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_GAIN     = 2'd0,
      CSR_SLOPE          = 2'd1,
      CSR_DENSITY_OFFSET = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               zero;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SUM,
      BACK_AVG,
      BACK_SLOPE,
      BACK_DENS,
      BACK_OUT
   } back_state_type;

endpackage

// ----- rtl/dust_sensor_window_average.sv -----
// Dust sensor window average. Each pushed word (10-bit ADC sample plus the
// supply reference in mV) yields one result word: the moving average of the
// last 25 scaled samples (scale_gain*sample/reference, saturated to 16 bits,
// 65535 with reference_zero set when the reference is 0; sum taken modulo
// 65536, slots not yet filled count as zero) and the dust density
// avg*slope/100 - offset in 0.001 mg/m3, two's complement. The front end
// runs each word through its bit-serial 26-step divider (skipped when the
// reference is zero) and takes a new word only once it has handed the
// last one on to the queue; the back end works on earlier words meanwhile.
// A two-word queue sits between front and back and a one-word output
// register holds the result; full is high while the front end works on a
// word, and stays high once those buffers fill and results wait to be
// popped. CSR writes (csr_ready is always high) are meant for when the
// block is idle.
module dust_sensor_window_average (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [dswa_pkg::SAMPLE_W-1:0]         req_raw_sample,
   input  logic [dswa_pkg::REF_W-1:0]            req_reference_mv,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [dswa_pkg::VALUE_W-1:0]          rsp_window_average,
   output logic signed [dswa_pkg::DENSITY_W-1:0] rsp_dust_density,
   output logic                                  rsp_reference_zero,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dswa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dswa_pkg::CSR_DAT_W-1:0]        csr_data
);

   logic [dswa_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic [dswa_pkg::SLOPE_W-1:0]  slope_ff, slope_in;
   logic [dswa_pkg::OFFSET_W-1:0] offset_ff, offset_in;

   logic                q_push, q_full, q_pop, q_empty;
   dswa_pkg::entry_type q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      gain_in   = gain_ff;
      slope_in  = slope_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         case (dswa_pkg::csr_index_type'(csr_index))
            dswa_pkg::CSR_SCALE_GAIN:     gain_in   = csr_data[dswa_pkg::GAIN_W-1:0];
            dswa_pkg::CSR_SLOPE:          slope_in  = csr_data[dswa_pkg::SLOPE_W-1:0];
            dswa_pkg::CSR_DENSITY_OFFSET: offset_in = csr_data[dswa_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= dswa_pkg::GAIN_RESET;
         slope_ff  <= dswa_pkg::SLOPE_RESET;
         offset_ff <= dswa_pkg::OFFSET_RESET;
      end else begin
         gain_ff   <= gain_in;
         slope_ff  <= slope_in;
         offset_ff <= offset_in;
      end
   end

   dswa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .raw_sample   (req_raw_sample),
      .reference_mv (req_reference_mv),
      .scale_gain   (gain_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   dswa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_wdata (q_wdata),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_rdata (q_rdata)
   );

   dswa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_data           (q_rdata),
      .slope_hundredths (slope_ff),
      .density_offset   (offset_ff),
      .empty            (empty),
      .pop              (pop),
      .window_average   (rsp_window_average),
      .dust_density     (rsp_dust_density),
      .reference_zero   (rsp_reference_zero)
   );

endmodule

// ----- rtl/dswa_front.sv -----
module dswa_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [dswa_pkg::SAMPLE_W-1:0]     raw_sample,
   input  logic [dswa_pkg::REF_W-1:0]        reference_mv,
   input  logic [dswa_pkg::GAIN_W-1:0]       scale_gain,
   input  logic                              q_full,
   output logic                              q_push,
   output dswa_pkg::entry_type               q_data
);

   dswa_pkg::front_state_type state_ff, state_in;
   logic [dswa_pkg::PROD_W-1:0] dividend_ff, dividend_in;
   logic [dswa_pkg::REF_W-1:0]  rem_ff, rem_in;
   logic [dswa_pkg::REF_W-1:0]  divisor_ff, divisor_in;
   logic [dswa_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        zero_ff, zero_in;
   logic [dswa_pkg::REF_W:0]    partial;

   assign full = (state_ff != dswa_pkg::FRONT_IDLE);

   // dividend register turns into the quotient as bits shift in
   assign q_data.zero  = zero_ff;
   assign q_data.value = (|dividend_ff[dswa_pkg::PROD_W-1:dswa_pkg::VALUE_W])
                         ? '1 : dividend_ff[dswa_pkg::VALUE_W-1:0];

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      step_in     = step_ff;
      zero_in     = zero_ff;
      q_push      = 1'b0;
      partial     = {rem_ff, dividend_ff[dswa_pkg::PROD_W-1]};
      case (state_ff)
         dswa_pkg::FRONT_IDLE: begin
            if (push) begin
               divisor_in = reference_mv;
               rem_in     = '0;
               step_in    = '0;
               zero_in    = (reference_mv == '0);
               if (reference_mv == '0) begin
                  dividend_in = '1;
                  state_in    = dswa_pkg::FRONT_PUSH;
               end else begin
                  dividend_in = dswa_pkg::PROD_W'(scale_gain) *
                                dswa_pkg::PROD_W'(raw_sample);
                  state_in    = dswa_pkg::FRONT_DIV;
               end
            end
         end
         dswa_pkg::FRONT_DIV: begin
            if (partial >= {1'b0, divisor_ff}) begin
               rem_in      = dswa_pkg::REF_W'(partial - {1'b0, divisor_ff});
               dividend_in = {dividend_ff[dswa_pkg::PROD_W-2:0], 1'b1};
            end else begin
               rem_in      = partial[dswa_pkg::REF_W-1:0];
               dividend_in = {dividend_ff[dswa_pkg::PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == dswa_pkg::STEP_W'(dswa_pkg::PROD_W - 1)) begin
               state_in = dswa_pkg::FRONT_PUSH;
            end
         end
         dswa_pkg::FRONT_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = dswa_pkg::FRONT_IDLE;
            end
         end
         default: state_in = dswa_pkg::FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dswa_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      step_ff     <= step_in;
      zero_ff     <= zero_in;
   end

endmodule

// ----- rtl/dswa_queue.sv -----
module dswa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   output logic                q_full,
   input  dswa_pkg::entry_type q_wdata,
   input  logic                q_pop,
   output logic                q_empty,
   output dswa_pkg::entry_type q_rdata
);

   dswa_pkg::entry_type mem_ff [dswa_pkg::QUEUE_DEPTH];
   logic [dswa_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dswa_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dswa_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign q_full  = (count_ff == dswa_pkg::QCNT_W'(dswa_pkg::QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_rdata = mem_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dswa_pkg::QPTR_W'(dswa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dswa_pkg::QPTR_W'(dswa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

// ----- rtl/dswa_back.sv -----
module dswa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   output logic                                q_pop,
   input  dswa_pkg::entry_type                 q_data,
   input  logic [dswa_pkg::SLOPE_W-1:0]        slope_hundredths,
   input  logic [dswa_pkg::OFFSET_W-1:0]       density_offset,
   output logic                                empty,
   input  logic                                pop,
   output logic [dswa_pkg::VALUE_W-1:0]        window_average,
   output logic signed [dswa_pkg::DENSITY_W-1:0] dust_density,
   output logic                                reference_zero
);

   dswa_pkg::back_state_type state_ff, state_in;

   // Window kept as a ring: the pointer steps through the slots in order,
   // so the slot overwritten is always the oldest one.
   logic [dswa_pkg::VALUE_W-1:0] store_ff [dswa_pkg::WINDOW_SIZE];
   logic [dswa_pkg::VALUE_W-1:0] old_ff;
   logic                         store_rd, store_we;

   logic [dswa_pkg::PTR_W-1:0]      ptr_ff, ptr_in;
   logic                            wrapped_ff, wrapped_in;
   logic [dswa_pkg::VALUE_W-1:0]    sum_ff, sum_in;
   logic [dswa_pkg::VALUE_W-1:0]    new_ff, new_in;
   logic                            zero_ff, zero_in;
   logic [dswa_pkg::AVG_PROD_W-1:0] avg_prod_ff, avg_prod_in;
   logic [dswa_pkg::VALUE_W-1:0]    avg_ff, avg_in;
   logic [dswa_pkg::SCALED_W-1:0]   scaled_ff, scaled_in;
   logic [dswa_pkg::PCT_PROD_W-1:0] pct_prod_ff, pct_prod_in;
   logic [dswa_pkg::QUOT_W-1:0]     quot;
   logic [dswa_pkg::VALUE_W-1:0]    old_value;

   logic                                out_valid_ff, out_valid_in;
   logic [dswa_pkg::VALUE_W-1:0]        out_avg_ff, out_avg_in;
   logic [dswa_pkg::DENSITY_W-1:0]      out_dens_ff, out_dens_in;
   logic                                out_zero_ff, out_zero_in;

   assign empty          = !out_valid_ff;
   assign window_average = out_avg_ff;
   assign dust_density   = $signed(out_dens_ff);
   assign reference_zero = out_zero_ff;

   // slots not yet written since reset still read as zero
   assign old_value = wrapped_ff ? old_ff : '0;
   assign quot      = dswa_pkg::QUOT_W'(pct_prod_ff >> dswa_pkg::PCT_SHIFT);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      wrapped_in   = wrapped_ff;
      sum_in       = sum_ff;
      new_in       = new_ff;
      zero_in      = zero_ff;
      avg_prod_in  = avg_prod_ff;
      avg_in       = avg_ff;
      scaled_in    = scaled_ff;
      pct_prod_in  = pct_prod_ff;
      out_avg_in   = out_avg_ff;
      out_dens_in  = out_dens_ff;
      out_zero_in  = out_zero_ff;
      out_valid_in = out_valid_ff && !pop;
      q_pop        = 1'b0;
      store_rd     = 1'b0;
      store_we     = 1'b0;
      case (state_ff)
         dswa_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               store_rd = 1'b1;
               new_in   = q_data.value;
               zero_in  = q_data.zero;
               state_in = dswa_pkg::BACK_SUM;
            end
         end
         dswa_pkg::BACK_SUM: begin
            store_we = 1'b1;
            sum_in   = sum_ff - old_value + new_ff;
            if (ptr_ff == dswa_pkg::PTR_W'(dswa_pkg::WINDOW_SIZE - 1)) begin
               ptr_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
            state_in = dswa_pkg::BACK_AVG;
         end
         dswa_pkg::BACK_AVG: begin
            avg_prod_in = dswa_pkg::AVG_PROD_W'(sum_ff) *
                          dswa_pkg::AVG_PROD_W'(dswa_pkg::AVG_RECIP);
            state_in    = dswa_pkg::BACK_SLOPE;
         end
         dswa_pkg::BACK_SLOPE: begin
            avg_in    = dswa_pkg::VALUE_W'(avg_prod_ff >> dswa_pkg::AVG_SHIFT);
            scaled_in = dswa_pkg::SCALED_W'(avg_in) *
                        dswa_pkg::SCALED_W'(slope_hundredths);
            state_in  = dswa_pkg::BACK_DENS;
         end
         dswa_pkg::BACK_DENS: begin
            pct_prod_in = dswa_pkg::PCT_PROD_W'(scaled_ff) *
                          dswa_pkg::PCT_PROD_W'(dswa_pkg::PCT_RECIP);
            state_in    = dswa_pkg::BACK_OUT;
         end
         dswa_pkg::BACK_OUT: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               out_avg_in   = avg_ff;
               out_zero_in  = zero_ff;
               out_dens_in  = dswa_pkg::DENSITY_W'(quot) -
                              dswa_pkg::DENSITY_W'(density_offset);
               state_in     = dswa_pkg::BACK_IDLE;
            end
         end
         default: state_in = dswa_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dswa_pkg::BACK_IDLE;
         ptr_ff       <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      zero_ff     <= zero_in;
      avg_prod_ff <= avg_prod_in;
      avg_ff      <= avg_in;
      scaled_ff   <= scaled_in;
      pct_prod_ff <= pct_prod_in;
      out_avg_ff  <= out_avg_in;
      out_dens_ff <= out_dens_in;
      out_zero_ff <= out_zero_in;
   end

   always_ff @(posedge clock) begin
      if (store_rd) begin
         old_ff <= store_ff[ptr_ff];
      end
      if (store_we) begin
         store_ff[ptr_ff] <= new_ff;
      end
   end

endmodule
